### sv/vr2l_pkg.sv
// Shared types for the 2D vector rescale pipeline.
`default_nettype none
package vr2l_pkg;

   localparam int unsigned COMP_W  = 32;
   localparam int unsigned TGT_W   = 31;
   localparam int unsigned SUM_W   = 2 * COMP_W;
   localparam int unsigned REM_W   = COMP_W + 2;
   localparam int unsigned PROD_W  = COMP_W + TGT_W;
   localparam int unsigned SQRT_CELLS = COMP_W;
   localparam int unsigned DIV_CELLS  = TGT_W;

   typedef struct packed {
      logic signed [COMP_W-1:0] vec_x;
      logic signed [COMP_W-1:0] vec_y;
      logic [TGT_W-1:0]         target_length;
   } req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] out_x;
      logic signed [COMP_W-1:0] out_y;
      logic [COMP_W-1:0]        length_in;
      logic                     was_zero;
   } rsp_type;

   // One stage of the root chain.
   typedef struct packed {
      logic [SUM_W-1:0]  sum;
      logic [REM_W-1:0]  rem;
      logic [COMP_W-1:0] root;
      logic [COMP_W-1:0] ax;
      logic [COMP_W-1:0] ay;
      logic              nx;
      logic              ny;
      logic [TGT_W-1:0]  tgt;
   } sq_type;

   // One stage of the divider chain, both lanes.
   typedef struct packed {
      logic [COMP_W-1:0] rem_x;
      logic [COMP_W-1:0] rem_y;
      logic [TGT_W-1:0]  low_x;
      logic [TGT_W-1:0]  low_y;
      logic [TGT_W-1:0]  quo_x;
      logic [TGT_W-1:0]  quo_y;
      logic [COMP_W-1:0] len;
      logic              nx;
      logic              ny;
   } dv_type;

endpackage
`default_nettype wire

### sv/vr2l_sqrt_cell.sv
// One digit cell of the integer square root chain.
`default_nettype none
module vr2l_sqrt_cell (
   input  wire logic            clock,
   input  wire logic            enable,
   input  wire vr2l_pkg::sq_type d,
   output vr2l_pkg::sq_type     q
);

   vr2l_pkg::sq_type q_ff, q_in;
   logic [vr2l_pkg::REM_W+1:0] part;
   logic [vr2l_pkg::REM_W+1:0] trial;

   always_comb begin
      q_in  = d;
      part  = {d.rem, d.sum[vr2l_pkg::SUM_W-1 -: 2]};
      trial = {2'b00, d.root, 2'b01};
      q_in.sum = {d.sum[vr2l_pkg::SUM_W-3:0], 2'b00};
      if (part >= trial) begin
         q_in.rem  = vr2l_pkg::REM_W'(part - trial);
         q_in.root = {d.root[vr2l_pkg::COMP_W-2:0], 1'b1};
      end else begin
         q_in.rem  = vr2l_pkg::REM_W'(part);
         q_in.root = {d.root[vr2l_pkg::COMP_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule
`default_nettype wire

### sv/vr2l_div_cell.sv
// One quotient-bit cell of the restoring divider chain, x and y lanes.
`default_nettype none
module vr2l_div_cell (
   input  wire logic            clock,
   input  wire logic            enable,
   input  wire vr2l_pkg::dv_type d,
   output vr2l_pkg::dv_type     q
);

   vr2l_pkg::dv_type q_ff, q_in;
   logic [vr2l_pkg::COMP_W:0] part_x;
   logic [vr2l_pkg::COMP_W:0] part_y;
   logic [vr2l_pkg::COMP_W:0] dvs;

   always_comb begin
      q_in   = d;
      dvs    = {1'b0, d.len};
      part_x = {d.rem_x, d.low_x[vr2l_pkg::TGT_W-1]};
      part_y = {d.rem_y, d.low_y[vr2l_pkg::TGT_W-1]};
      q_in.low_x = {d.low_x[vr2l_pkg::TGT_W-2:0], 1'b0};
      q_in.low_y = {d.low_y[vr2l_pkg::TGT_W-2:0], 1'b0};
      if (part_x >= dvs) begin
         q_in.rem_x = vr2l_pkg::COMP_W'(part_x - dvs);
         q_in.quo_x = {d.quo_x[vr2l_pkg::TGT_W-2:0], 1'b1};
      end else begin
         q_in.rem_x = vr2l_pkg::COMP_W'(part_x);
         q_in.quo_x = {d.quo_x[vr2l_pkg::TGT_W-2:0], 1'b0};
      end
      if (part_y >= dvs) begin
         q_in.rem_y = vr2l_pkg::COMP_W'(part_y - dvs);
         q_in.quo_y = {d.quo_y[vr2l_pkg::TGT_W-2:0], 1'b1};
      end else begin
         q_in.rem_y = vr2l_pkg::COMP_W'(part_y);
         q_in.quo_y = {d.quo_y[vr2l_pkg::TGT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule
`default_nettype wire

### sv/vector2d_rescale_to_length.sv
// Top level of the 2D vector rescale pipeline.
// Rescales a signed Q16.16 vector to a target length: L = floor(sqrt(x^2+y^2)),
// out = trunc(v * T / L), with a zero vector and was_zero set when L is zero.
// The block takes one transaction per cycle unless a result is stalled. Stages:
// input register, squares, sum, 32 root cells, products, 31 divider cells and the
// output register. The whole pipeline holds while a result is stalled.
`default_nettype none
module vector2d_rescale_to_length (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire vr2l_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      vr2l_pkg::rsp_type rsp_data
);

   localparam int unsigned NSQ = vr2l_pkg::SQRT_CELLS;
   localparam int unsigned NDV = vr2l_pkg::DIV_CELLS;
   localparam int unsigned CW  = vr2l_pkg::COMP_W;
   localparam int unsigned TW  = vr2l_pkg::TGT_W;

   logic enable;

   // front stages
   logic                  v0_ff, v1_ff, v2_ff;
   logic [CW-1:0]         ax0_ff, ay0_ff, ax1_ff, ay1_ff;
   logic                  nx0_ff, ny0_ff, nx1_ff, ny1_ff;
   logic [TW-1:0]         t0_ff, t1_ff;
   logic [vr2l_pkg::SUM_W-1:0] sqx_ff, sqy_ff;
   vr2l_pkg::sq_type      sq_head_ff;

   // chains
   logic [NSQ-1:0]        sq_v_ff;
   vr2l_pkg::sq_type      sq_link [NSQ+1];
   logic                  pm_v_ff;
   logic [vr2l_pkg::PROD_W-1:0] px_ff, py_ff;
   logic [CW-1:0]         pm_len_ff;
   logic                  pm_nx_ff, pm_ny_ff;
   vr2l_pkg::dv_type      dv_head;
   logic [NDV-1:0]        dv_v_ff;
   vr2l_pkg::dv_type      dv_link [NDV+1];

   logic                  rsp_valid_ff;
   vr2l_pkg::rsp_type     rsp_data_ff, rsp_data_in;
   vr2l_pkg::dv_type      dv_tail;

   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         sq_v_ff      <= '0;
         pm_v_ff      <= 1'b0;
         dv_v_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         v0_ff        <= req_valid;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         sq_v_ff      <= {sq_v_ff[NSQ-2:0], v2_ff};
         pm_v_ff      <= sq_v_ff[NSQ-1];
         dv_v_ff      <= {dv_v_ff[NDV-2:0], pm_v_ff};
         rsp_valid_ff <= dv_v_ff[NDV-1];
      end
   end

   // magnitudes, squares, sum
   always_ff @(posedge clock) begin
      if (enable) begin
         nx0_ff <= req_data.vec_x[CW-1];
         ny0_ff <= req_data.vec_y[CW-1];
         ax0_ff <= req_data.vec_x[CW-1] ? CW'(~req_data.vec_x + 1'b1) : req_data.vec_x;
         ay0_ff <= req_data.vec_y[CW-1] ? CW'(~req_data.vec_y + 1'b1) : req_data.vec_y;
         t0_ff  <= req_data.target_length;

         sqx_ff <= ax0_ff * ax0_ff;
         sqy_ff <= ay0_ff * ay0_ff;
         ax1_ff <= ax0_ff;
         ay1_ff <= ay0_ff;
         nx1_ff <= nx0_ff;
         ny1_ff <= ny0_ff;
         t1_ff  <= t0_ff;

         sq_head_ff.sum  <= sqx_ff + sqy_ff;
         sq_head_ff.rem  <= '0;
         sq_head_ff.root <= '0;
         sq_head_ff.ax   <= ax1_ff;
         sq_head_ff.ay   <= ay1_ff;
         sq_head_ff.nx   <= nx1_ff;
         sq_head_ff.ny   <= ny1_ff;
         sq_head_ff.tgt  <= t1_ff;
      end
   end

   assign sq_link[0] = sq_head_ff;

   for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
      vr2l_sqrt_cell u_cell (
         .clock  (clock),
         .enable (enable),
         .d      (sq_link[i]),
         .q      (sq_link[i+1])
      );
   end

   // products of magnitude and target
   always_ff @(posedge clock) begin
      if (enable) begin
         px_ff     <= sq_link[NSQ].ax * sq_link[NSQ].tgt;
         py_ff     <= sq_link[NSQ].ay * sq_link[NSQ].tgt;
         pm_len_ff <= sq_link[NSQ].root;
         pm_nx_ff  <= sq_link[NSQ].nx;
         pm_ny_ff  <= sq_link[NSQ].ny;
      end
   end

   // quotient fits in TW bits since |v| <= L, so upper part starts below L
   always_comb begin
      dv_head.rem_x = px_ff[vr2l_pkg::PROD_W-1:TW];
      dv_head.rem_y = py_ff[vr2l_pkg::PROD_W-1:TW];
      dv_head.low_x = px_ff[TW-1:0];
      dv_head.low_y = py_ff[TW-1:0];
      dv_head.quo_x = '0;
      dv_head.quo_y = '0;
      dv_head.len   = pm_len_ff;
      dv_head.nx    = pm_nx_ff;
      dv_head.ny    = pm_ny_ff;
   end

   assign dv_link[0] = dv_head;

   for (genvar j = 0; j < NDV; j++) begin : g_div
      vr2l_div_cell u_cell (
         .clock  (clock),
         .enable (enable),
         .d      (dv_link[j]),
         .q      (dv_link[j+1])
      );
   end

   assign dv_tail = dv_link[NDV];

   always_comb begin
      rsp_data_in.length_in = dv_tail.len;
      if (dv_tail.len == '0) begin
         rsp_data_in.out_x    = '0;
         rsp_data_in.out_y    = '0;
         rsp_data_in.was_zero = 1'b1;
      end else begin
         rsp_data_in.out_x    = dv_tail.nx ? CW'(-{1'b0, dv_tail.quo_x}) : CW'(dv_tail.quo_x);
         rsp_data_in.out_y    = dv_tail.ny ? CW'(-{1'b0, dv_tail.quo_y}) : CW'(dv_tail.quo_y);
         rsp_data_in.was_zero = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

### bench/vr2l_checker.sv
// Checker for the vector rescale block: predicts each result and compares it.
`default_nettype none
module vr2l_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire vr2l_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire vr2l_pkg::rsp_type rsp_data,
   output int                     fail_count,
   output int                     pending_count,
   output int                     result_count,
   output int                     zero_count
);

   vr2l_pkg::rsp_type expected_rsps[$];

   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] rescale_comp(input logic signed [31:0] v,
                                                input logic [63:0] tgt,
                                                input logic [63:0] len);
      logic [63:0] mag;
      logic [63:0] q;
      mag = v[31] ? 64'(-{32'd0, v} & 64'hFFFF_FFFF) : {32'd0, v};
      q = (mag * tgt) / len;
      if (v[31]) q = -q;
      return q[31:0];
   endfunction

   function automatic vr2l_pkg::rsp_type rescale_vector(input vr2l_pkg::req_type r);
      vr2l_pkg::rsp_type o;
      logic [63:0] ax, ay, len;
      ax = r.vec_x[31] ? 64'(-{32'd0, r.vec_x} & 64'hFFFF_FFFF) : {32'd0, r.vec_x};
      ay = r.vec_y[31] ? 64'(-{32'd0, r.vec_y} & 64'hFFFF_FFFF) : {32'd0, r.vec_y};
      len = floor_root(ax * ax + ay * ay);
      o = '0;
      if (len == 0) begin
         o.was_zero = 1'b1;
      end else begin
         o.out_x = rescale_comp(r.vec_x, {33'd0, r.target_length}, len);
         o.out_y = rescale_comp(r.vec_y, {33'd0, r.target_length}, len);
         o.length_in = len[31:0];
      end
      return o;
   endfunction

   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      vr2l_pkg::rsp_type want;
      if (reset) begin
         fail_count <= 0;
         result_count <= 0;
         zero_count <= 0;
      end else begin
         if (req_valid && !req_stall) expected_rsps.push_back(rescale_vector(req_data));
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (rsp_data.was_zero) zero_count <= zero_count + 1;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected transaction %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (want.out_x !== rsp_data.out_x || want.out_y !== rsp_data.out_y ||
                   want.length_in !== rsp_data.length_in ||
                   want.was_zero !== rsp_data.was_zero) begin
                  $display("%0t: mismatch expected x=%h y=%h len=%h z=%b", $time,
                           want.out_x, want.out_y, want.length_in, want.was_zero);
                  $display("%0t:          actual   x=%h y=%h len=%h z=%b", $time,
                           rsp_data.out_x, rsp_data.out_y, rsp_data.length_in,
                           rsp_data.was_zero);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

### bench/tb_top.sv
// Testbench top for the vector rescale block: stimulus, stalls and verdict.
`default_nettype none
module tb_top;

   localparam int LATENCY = 68;
   localparam int RANDOM_ITEMS = 500;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   vr2l_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   vr2l_pkg::rsp_type rsp_data;
   int      fail_count, pending_count, result_count, zero_count;
   int      item_count = 0;
   bit      hold_off = 1'b0;
   bit      stim_done = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   vector2d_rescale_to_length u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   vr2l_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .fail_count, .pending_count, .result_count, .zero_count
   );

   function automatic int gap_length();
      if ($urandom_range(9) < 8) return $urandom_range(2);
      return $urandom_range(30, 5);
   endfunction

   function automatic logic [31:0] random_comp();
      case ($urandom_range(5))
         0: return $urandom_range(8) - 4;
         1: return 32'h8000_0000 + $urandom_range(3);
         2: return 32'h7FFF_FFFF - $urandom_range(3);
         3: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] random_target();
      case ($urandom_range(4))
         0: return 31'h0001_0000;
         1: return 31'($urandom_range(2));
         2: return 31'(32'h7FFF_FFFF - $urandom_range(2));
         default: return 31'($urandom);
      endcase
   endfunction

   // Offer one transaction and hold it until accepted.
   task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                              input logic [30:0] t, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{vec_x: x, vec_y: y, target_length: t};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      item_count++;
   endtask

   // Receiver stalls, with one long hold-off while the sender keeps going.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
            rsp_stall <= 1'b0;
         end else if (item_count > 300 && item_count < 380) begin
            rsp_stall <= 1'b0;
         end else if ($urandom_range(7) == 0) begin
            n = gap_length() + 1;
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [31:0] ext[6];
      int i;
      ext = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // zero vector, axes, extreme corners, zero and maximum target
      send_vector(32'h0, 32'h0, 31'h0001_0000, 1'b0);
      send_vector(32'h0, 32'h0, 31'h7FFF_FFFF, 1'b0);
      for (i = 0; i < 6; i++) begin
         send_vector(ext[i], ext[(i + 2) % 6], 31'h0001_0000, 1'b0);
         send_vector(ext[i], ext[5 - i], 31'h7FFF_FFFF, 1'b1);
      end
      send_vector(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0);
      send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
      send_vector(32'h0003_0000, 32'hFFFC_0000, 31'h0, 1'b0);
      send_vector(32'h0003_0000, 32'hFFFC_0000, 31'h0005_0000, 1'b0);
      send_vector(32'd3, 32'd4, 31'h1, 1'b0);
      send_vector(32'd1, 32'd1, 31'h0001_0000, 1'b0);
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 250) hold_off = 1'b1;
         send_vector(random_comp(), random_comp(), random_target(), $urandom_range(3) == 0);
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d vectors, checked %0d results (%0d zero-length).",
               item_count, result_count, zero_count);
      $display("Covered component and target extremes, random stalls and a long output hold.");
      if (fail_count == 0 && pending_count == 0)
         $display("vector2d_rescale_to_length regression: pass");
      else
         $display("vector2d_rescale_to_length regression: fail");
      $finish;
   end

   initial begin
      #2000000;
      $display("vector2d_rescale_to_length regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
sv/vr2l_pkg.sv
sv/vr2l_sqrt_cell.sv
sv/vr2l_div_cell.sv
sv/vector2d_rescale_to_length.sv
bench/vr2l_checker.sv
bench/tb_top.sv
